// ===== sv/transport_receiver_state_machine_macros.svh =====
// Assertion macros for the transport receiver top level.
`ifndef TRANSPORT_RECEIVER_STATE_MACHINE_MACROS_SVH
`define TRANSPORT_RECEIVER_STATE_MACHINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TRSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define TRSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/trsm_pkg.sv =====
// Types and constants of the transport receiver.
package trsm_pkg;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_WAIT    = 3'd1,
    ST_NEGO    = 3'd2,
    ST_CONN    = 3'd3,
    ST_CLOSING = 3'd4
  } conn_state_t;

  localparam logic [31:0] CODE_CONT = 32'hFFFF_FFFF;
  localparam logic [31:0] CODE_END  = 32'hFFFF_FFFE;

  localparam logic REQ_HEADER = 1'b0;
  localparam logic REQ_OPEN   = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] dst_port;
    logic        flag_syn;
    logic        flag_ack;
    logic        flag_fin;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
  } hdr_t;

  typedef struct packed {
    logic        reply_valid;
    logic        reply_syn;
    logic        reply_ackflag;
    logic        reply_fin;
    logic [31:0] reply_seq;
    logic [31:0] reply_acknum;
    logic        deliver;
    logic        connected_now;
  } rsp_t;

endpackage

// ===== sv/trsm_chan_if.sv =====
// Valid/ready channel carrying one word of type T.
interface trsm_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/trsm_core.sv =====
// Connection state machine: state registers and per-word result logic.
module trsm_core
  import trsm_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  hdr_t        word,
  input  logic [15:0] local_port,
  output rsp_t        result
);

  conn_state_t           state, state_next;
  logic [31:0]           last_seq, last_seq_next;
  logic [COUNT_BITS-1:0] nego_count, nego_count_next;

  logic is_syn, is_ack, is_fin, open;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_NONE;
      last_seq   <= '1;
      nego_count <= '0;
    end else if (step) begin
      state      <= state_next;
      last_seq   <= last_seq_next;
      nego_count <= nego_count_next;
    end
  end

  assign is_syn = word.flag_syn & ~word.flag_ack & ~word.flag_fin;
  assign is_ack = ~word.flag_syn & word.flag_ack & ~word.flag_fin;
  assign is_fin = ~word.flag_syn & ~word.flag_ack & word.flag_fin;
  assign open   = state inside {ST_WAIT, ST_NEGO, ST_CONN, ST_CLOSING};

  always_comb begin
    state_next      = state;
    last_seq_next   = last_seq;
    nego_count_next = nego_count;
    result          = '0;
    if (word.req_type == REQ_OPEN) begin
      state_next    = ST_WAIT;
      last_seq_next = '1;
    end else if (!open || word.dst_port != local_port) begin
      if (is_fin) begin
        result.reply_valid   = 1'b1;
        result.reply_ackflag = 1'b1;
        result.reply_fin     = 1'b1;
      end
    end else begin
      case (state)
        ST_WAIT: begin
          if (is_syn) begin
            result.reply_valid   = 1'b1;
            result.reply_syn     = 1'b1;
            result.reply_ackflag = 1'b1;
            state_next           = ST_NEGO;
          end
        end
        ST_NEGO: begin
          if (is_syn) begin
            result.reply_valid   = 1'b1;
            result.reply_syn     = 1'b1;
            result.reply_ackflag = 1'b1;
          end else if (is_ack) begin
            // handshake ACK: drop silently
          end else if (word.ack_number == CODE_CONT) begin
            if (nego_count != '1) begin
              nego_count_next = nego_count + 1'b1;
            end
          end else if (word.ack_number == CODE_END) begin
            result.reply_valid   = 1'b1;
            result.reply_seq     = 32'(nego_count);
            result.reply_acknum  = CODE_END;
            result.connected_now = 1'b1;
            state_next           = ST_CONN;
          end
        end
        ST_CONN: begin
          if (is_fin) begin
            result.reply_valid   = 1'b1;
            result.reply_ackflag = 1'b1;
            result.reply_fin     = 1'b1;
            state_next           = ST_CLOSING;
          end else if (word.ack_number == CODE_END) begin
            result.reply_valid  = 1'b1;
            result.reply_seq    = 32'(nego_count);
            result.reply_acknum = CODE_END;
          end else begin
            // ack the word's sequence; it is last_seq afterwards either way
            result.reply_valid   = 1'b1;
            result.reply_ackflag = 1'b1;
            result.reply_acknum  = word.seq_number;
            result.deliver       = (word.seq_number != last_seq);
            last_seq_next        = word.seq_number;
          end
        end
        default: begin
          result.reply_valid   = 1'b1;
          result.reply_ackflag = 1'b1;
          result.reply_fin     = 1'b1;
          state_next           = ST_NONE;
        end
      endcase
    end
  end

endmodule

// ===== sv/trsm_rsp_reg.sv =====
// Result register driving the response channel.
module trsm_rsp_reg
  import trsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  rsp_t               result,
  output logic               free,
  trsm_chan_if.source        rsp
);

  logic held;
  rsp_t word;

  assign free      = ~held | rsp.ready;
  assign rsp.valid = held;
  assign rsp.data  = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= 1'b1;
    end else if (rsp.ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word <= result;
    end
  end

endmodule

// ===== sv/transport_receiver_state_machine.sv =====
// Transport receiver: server-side connection state machine, top level.
//
// Channels (valid/ready, a word moves on an edge with both high):
//   cfg - one 16-bit word, the local port; always ready. Write it only
//         while no word is in flight; it applies to the next header.
//   hdr - one event word: open-and-listen request or a received header.
//   rsp - exactly one result word per hdr word, in order: optional reply
//         header (reply_valid), deliver flag and connected_now flag.
// Registers: a hdr word is held in the input register, then in the
//   result register, which drives rsp.
// Throughput: one word per cycle while rsp is taken. Path: input register,
//   state logic with the connection state registers, result register.
// Stall: when rsp is not taken the result register holds; the input
//   register holds behind it, and hdr.ready drops once both are full.
// Reset (rst, synchronous): no socket open, last sequence all ones,
//   negotiation count zero, local port zero, both stages empty.
module transport_receiver_state_machine
  import trsm_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  trsm_chan_if.sink   cfg,
  trsm_chan_if.sink   hdr,
  trsm_chan_if.source rsp
);

`include "transport_receiver_state_machine_macros.svh"

  logic [15:0] local_port;

  // input stage
  logic in_full;
  hdr_t in_word;

  // hand-off between stages
  logic out_free;
  logic advance;
  rsp_t result;

  // Config register: always ready, take the word as written.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_port <= '0;
    end else if (cfg.valid) begin
      local_port <= cfg.data;
    end
  end

  // Advance the input word into the result register when it has room.
  assign advance   = in_full & out_free;
  assign hdr.ready = ~in_full | out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (hdr.ready) begin
      in_full <= hdr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr.valid & hdr.ready) begin
      in_word <= hdr.data;
    end
  end

  // State updates happen in the cycle the word moves on, so each word
  // sees what the one before it left.
  trsm_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .word       (in_word),
    .local_port (local_port),
    .result     (result)
  );

  trsm_rsp_reg u_rsp_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (advance),
    .result (result),
    .free   (out_free),
    .rsp    (rsp)
  );

  `TRSM_ASSERT_NOW(a_connect_reply, advance && result.connected_now, result.reply_valid && result.reply_acknum == CODE_END, "connect without end reply")
  `TRSM_ASSERT_NOW(a_quiet_zero, advance && !result.reply_valid, result.reply_seq == '0 && result.reply_acknum == '0 && !result.reply_ackflag && !result.deliver, "reply fields set without reply")
  `TRSM_ASSERT_NOW(a_deliver_ack, advance && result.deliver, result.reply_ackflag && !result.reply_fin && result.reply_acknum == in_word.seq_number, "delivered word not acked")
  `TRSM_ASSERT_NEXT(a_hold_input, in_full && !out_free, in_full && $stable(in_word), "input word lost under stall")

endmodule
